// File: hdl/lsi_pkg.sv
// Shared types and constants for the line and sphere intersection pipeline.
package lsi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int CSR_WIDTH       = 32;

   localparam logic [CSR_WIDTH-1:0] TOL_RESET = 32'd4295;

   typedef enum logic [1:0] {
      HIT_NONE    = 2'd0,
      HIT_TANGENT = 2'd1,
      HIT_TWO     = 2'd2
   } hit_type;

   typedef struct packed {
      logic    valid;
      hit_type hits;
   } ctl_type;

endpackage

// File: hdl/line_sphere_intersect_top.sv
// Top level of the line and sphere intersection pipeline.
//
//   channel  direction  handshake               contents
//   req_     in         req_valid / req_ready   origin, direction, center, radius
//   rsp_     out        rsp_valid / rsp_ready   hit count, t near/far, near/far points
//   csr_     in         csr_valid / csr_ready   tangent tolerance
//
// One request enters per cycle unless the response stalls; the pipeline depth is set
// mostly by the one-bit-per-stage square root.
// Reset clears all valid bits and loads the tolerance; data registers are not reset.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
module line_sphere_intersect_top import lsi_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [FRAC_BITS+1:0]   req_dir_x,
   input  logic signed [FRAC_BITS+1:0]   req_dir_y,
   input  logic signed [FRAC_BITS+1:0]   req_dir_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic [COORD_WIDTH-2:0]        req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_hit_count,
   output logic signed [COORD_WIDTH-1:0] rsp_t_near,
   output logic signed [COORD_WIDTH-1:0] rsp_t_far,
   output logic signed [COORD_WIDTH-1:0] rsp_near_x,
   output logic signed [COORD_WIDTH-1:0] rsp_near_y,
   output logic signed [COORD_WIDTH-1:0] rsp_near_z,
   output logic signed [COORD_WIDTH-1:0] rsp_far_x,
   output logic signed [COORD_WIDTH-1:0] rsp_far_y,
   output logic signed [COORD_WIDTH-1:0] rsp_far_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_WIDTH-1:0]          csr_tangent_tolerance
);

   localparam int DW  = FRAC_BITS + 2;
   localparam int A1W = DW + COORD_WIDTH + 3;
   localparam int OPW = 2 * A1W + 1;
   localparam int RW  = (OPW + 1) / 2;
   localparam int SW  = A1W + 3 * COORD_WIDTH + 3 * DW;

   logic en;
   logic [CSR_WIDTH-1:0] tol_ff;

   logic signed [COORD_WIDTH-1:0] org_arr [3], ctr_arr [3], f_org [3], b_org [3];
   logic signed [DW-1:0]          dir_arr [3], f_dir [3], b_dir [3];
   logic [COORD_WIDTH-1:0]        near_pt [3], far_pt [3];
   logic [1:0]                    unused_hits;

   ctl_type f_ctl, s_ctl, o_ctl;
   logic [OPW-1:0]         f_op;
   logic signed [A1W-1:0]  f_a1, b_a1;
   logic [SW-1:0]          f_side, s_side;
   logic [RW-1:0]          s_root;

   assign en        = !o_ctl.valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_tangent_tolerance;
      end
   end

   assign org_arr[0] = req_origin_x;
   assign org_arr[1] = req_origin_y;
   assign org_arr[2] = req_origin_z;
   assign dir_arr[0] = req_dir_x;
   assign dir_arr[1] = req_dir_y;
   assign dir_arr[2] = req_dir_z;
   assign ctr_arr[0] = req_center_x;
   assign ctr_arr[1] = req_center_y;
   assign ctr_arr[2] = req_center_z;

   lsi_front #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .org      (org_arr),
      .dir      (dir_arr),
      .ctr      (ctr_arr),
      .radius   (req_radius),
      .tol      (tol_ff),
      .out_ctl  (f_ctl),
      .out_op   (f_op),
      .out_a1   (f_a1),
      .out_org  (f_org),
      .out_dir  (f_dir)
   );

   assign f_side = {f_a1, f_org[0], f_org[1], f_org[2], f_dir[0], f_dir[1], f_dir[2]};

   lsi_isqrt #(.OPW(OPW), .SW(SW)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (f_ctl),
      .in_op    (f_op),
      .in_side  (f_side),
      .out_ctl  (s_ctl),
      .out_root (s_root),
      .out_side (s_side)
   );

   assign {b_a1, b_org[0], b_org[1], b_org[2], b_dir[0], b_dir[1], b_dir[2]} = s_side;

   lsi_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (s_ctl),
      .root    (s_root),
      .a1      (b_a1),
      .org     (b_org),
      .dir     (b_dir),
      .out_ctl (o_ctl),
      .t_near  (rsp_t_near),
      .t_far   (rsp_t_far),
      .near_pt (near_pt),
      .far_pt  (far_pt)
   );

   assign unused_hits   = o_ctl.hits;
   assign rsp_valid     = o_ctl.valid;
   assign rsp_hit_count = unused_hits;
   assign rsp_near_x    = near_pt[0];
   assign rsp_near_y    = near_pt[1];
   assign rsp_near_z    = near_pt[2];
   assign rsp_far_x     = far_pt[0];
   assign rsp_far_y     = far_pt[1];
   assign rsp_far_z     = far_pt[2];

endmodule

// File: hdl/lsi_front.sv
// Front pipeline: difference, dot products, discriminant and hit classification.
module lsi_front import lsi_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF,
   localparam int DW  = FB + 2,
   localparam int DFW = CW + 1,
   localparam int A1W = DW + DFW + 2,
   localparam int DSW = 2 * A1W + 2,
   localparam int OPW = DSW - 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] org [3],
   input  logic signed [DW-1:0] dir [3],
   input  logic signed [CW-1:0] ctr [3],
   input  logic [CW-2:0]        radius,
   input  logic [CSR_WIDTH-1:0] tol,
   output ctl_type              out_ctl,
   output logic [OPW-1:0]       out_op,
   output logic signed [A1W-1:0] out_a1,
   output logic signed [CW-1:0] out_org [3],
   output logic signed [DW-1:0] out_dir [3]
);

   localparam int PAW = DW + DFW;
   localparam int PQW = 2 * DFW;
   localparam int RRW = 2 * CW - 2;
   localparam int A0W = PQW + 3;
   localparam int HL  = (A1W + 1) / 2;
   localparam int HH  = A1W - HL;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   ctl_type ctl_ff;
   hit_type hits_in;

   logic signed [DFW-1:0] dif_ff [3];
   logic signed [CW-1:0]  o1_ff [3], o2_ff [3], o3_ff [3], o4_ff [3], o5_ff [3], o6_ff [3];
   logic signed [DW-1:0]  d1_ff [3], d2_ff [3], d3_ff [3], d4_ff [3], d5_ff [3], d6_ff [3];
   logic [CW-2:0]         r1_ff;
   logic signed [PAW-1:0] pa_ff [3];
   logic signed [PQW-1:0] pq_ff [3];
   logic [RRW-1:0]        rr_ff;
   logic signed [A1W-1:0] a1_ff, a1_4_ff, a1_5_ff, a1_6_ff;
   logic signed [A0W-1:0] a0_ff, a0_4_ff;
   logic signed [HH-1:0]  ah;
   logic [HL-1:0]         al;
   logic signed [2*HH-1:0] hh_ff;
   logic signed [HH+HL:0]  hl_ff;
   logic [2*HL-1:0]        ll_ff;
   logic signed [DSW-1:0]  disc_ff;
   logic [OPW-1:0]         op_ff;

   assign ah = a1_ff[A1W-1:HL];
   assign al = a1_ff[HL-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         ctl_ff <= '0;
      end else if (en) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         ctl_ff <= '{valid: v5_ff, hits: hits_in};
      end
   end

   always_comb begin
      if (disc_ff[DSW-1]) begin
         hits_in = HIT_NONE;
      end else if (disc_ff[DSW-2:0] < (DSW-1)'({tol, {(2*FB){1'b0}}})) begin
         hits_in = HIT_TANGENT;
      end else begin
         hits_in = HIT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dif_ff[i] <= DFW'(org[i]) - DFW'(ctr[i]);
            o1_ff[i]  <= org[i];
            d1_ff[i]  <= dir[i];
            pa_ff[i]  <= PAW'(d1_ff[i]) * PAW'(dif_ff[i]);
            pq_ff[i]  <= PQW'(dif_ff[i]) * PQW'(dif_ff[i]);
            o2_ff[i]  <= o1_ff[i];
            d2_ff[i]  <= d1_ff[i];
            o3_ff[i]  <= o2_ff[i];
            d3_ff[i]  <= d2_ff[i];
            o4_ff[i]  <= o3_ff[i];
            d4_ff[i]  <= d3_ff[i];
            o5_ff[i]  <= o4_ff[i];
            d5_ff[i]  <= d4_ff[i];
            o6_ff[i]  <= o5_ff[i];
            d6_ff[i]  <= d5_ff[i];
         end
         r1_ff   <= radius;
         rr_ff   <= RRW'(r1_ff) * RRW'(r1_ff);
         a1_ff   <= A1W'(pa_ff[0]) + A1W'(pa_ff[1]) + A1W'(pa_ff[2]);
         a0_ff   <= A0W'(pq_ff[0]) + A0W'(pq_ff[1]) + A0W'(pq_ff[2]) - A0W'(rr_ff);
         hh_ff   <= (2*HH)'(ah) * (2*HH)'(ah);
         hl_ff   <= (HH+HL+1)'(ah) * $signed((HH+HL+1)'(al));
         ll_ff   <= (2*HL)'(al) * (2*HL)'(al);
         a1_4_ff <= a1_ff;
         a0_4_ff <= a0_ff;
         disc_ff <= (DSW'(hh_ff) << (2*HL)) + (DSW'(hl_ff) << (HL+1)) + DSW'(ll_ff)
                    - (DSW'(a0_4_ff) << (2*FB));
         a1_5_ff <= a1_4_ff;
         op_ff   <= disc_ff[DSW-2:0];
         a1_6_ff <= a1_5_ff;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_op  = op_ff;
   assign out_a1  = a1_6_ff;
   assign out_org = o6_ff;
   assign out_dir = d6_ff;

endmodule

// File: hdl/lsi_isqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
module lsi_isqrt import lsi_pkg::*; #(
   parameter int OPW = 108,
   parameter int SW  = 8,
   localparam int RW = (OPW + 1) / 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  ctl_type        in_ctl,
   input  logic [OPW-1:0] in_op,
   input  logic [SW-1:0]  in_side,
   output ctl_type        out_ctl,
   output logic [RW-1:0]  out_root,
   output logic [SW-1:0]  out_side
);

   localparam int PW   = 2 * RW;
   localparam int REMW = RW + 2;

   ctl_type         ctl_ff  [RW];
   logic [PW-1:0]   x_ff    [RW];
   logic [REMW-1:0] rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [SW-1:0]   side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      ctl_type         ctl_cur;
      logic [PW-1:0]   x_cur;
      logic [REMW-1:0] rem_cur, rem_sh, trial, rem_in;
      logic [RW-1:0]   root_cur, root_in;
      logic [SW-1:0]   side_cur;

      if (k == 0) begin : g_first
         assign ctl_cur  = in_ctl;
         assign x_cur    = PW'(in_op);
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign ctl_cur  = ctl_ff[k-1];
         assign x_cur    = x_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_cur[REMW-3:0], x_cur[PW-1:PW-2]};
         trial  = {root_cur, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_cur[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_cur[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_cur << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_ctl  = ctl_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

// File: hdl/lsi_back.sv
// Back pipeline: line parameters, hit points, rounding, saturation and result register.
module lsi_back import lsi_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF,
   localparam int DW  = FB + 2,
   localparam int A1W = DW + CW + 3,
   localparam int RW  = A1W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  ctl_type               in_ctl,
   input  logic [RW-1:0]         root,
   input  logic signed [A1W-1:0] a1,
   input  logic signed [CW-1:0]  org [3],
   input  logic signed [DW-1:0]  dir [3],
   output ctl_type               out_ctl,
   output logic [CW-1:0]         t_near,
   output logic [CW-1:0]         t_far,
   output logic [CW-1:0]         near_pt [3],
   output logic [CW-1:0]         far_pt [3]
);

   localparam int TW   = A1W + 3;
   localparam int PW2  = TW + DW;
   localparam int SATW = PW2 + 2;
   localparam logic signed [SATW-1:0] SMAX = {{(SATW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SATW-1:0] SMIN = {{(SATW-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [SATW-1:0] HALF_T = SATW'(1) << (FB - 1);
   localparam logic signed [SATW-1:0] HALF_P = SATW'(1) << (2 * FB - 1);

   function automatic logic [CW-1:0] sat_w(input logic signed [SATW-1:0] v);
      if (v > SMAX) begin
         return SMAX[CW-1:0];
      end else if (v < SMIN) begin
         return SMIN[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   ctl_type c1_ff, c2_ff, c3_ff;
   logic signed [TW-1:0]  na, tn_in, tf_in, tn_ff, tf_ff;
   logic signed [CW-1:0]  o1_ff [3], o2_ff [3];
   logic signed [DW-1:0]  d1_ff [3];
   logic signed [PW2-1:0] pn_ff [3], pf_ff [3];
   logic [CW-1:0]         tno_ff, tfo_ff, tno3_ff, tfo3_ff;
   logic [CW-1:0]         nq_ff [3], fq_ff [3];
   logic signed [SATW-1:0] tnr, tfr;
   logic signed [SATW-1:0] npr [3], fpr [3];

   assign na    = -TW'(a1);
   assign tn_in = (in_ctl.hits == HIT_TWO) ? na - TW'(root) : na;
   assign tf_in = na + TW'(root);
   assign tnr   = (SATW'(tn_ff) + HALF_T) >>> FB;
   assign tfr   = (SATW'(tf_ff) + HALF_T) >>> FB;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         npr[i] = ((SATW'(pn_ff[i]) + HALF_P) >>> (2 * FB)) + SATW'(o2_ff[i]);
         fpr[i] = ((SATW'(pf_ff[i]) + HALF_P) >>> (2 * FB)) + SATW'(o2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else if (en) begin
         c1_ff <= in_ctl;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tn_ff  <= tn_in;
         tf_ff  <= tf_in;
         tno_ff <= sat_w(tnr);
         tfo_ff <= sat_w(tfr);
         for (int i = 0; i < 3; i++) begin
            o1_ff[i] <= org[i];
            d1_ff[i] <= dir[i];
            o2_ff[i] <= o1_ff[i];
            pn_ff[i] <= PW2'(tn_ff) * PW2'(d1_ff[i]);
            pf_ff[i] <= PW2'(tf_ff) * PW2'(d1_ff[i]);
            nq_ff[i] <= (c2_ff.hits == HIT_NONE) ? '0 : sat_w(npr[i]);
            fq_ff[i] <= (c2_ff.hits == HIT_TWO) ? sat_w(fpr[i]) : '0;
         end
         tno3_ff <= (c2_ff.hits == HIT_NONE) ? '0 : tno_ff;
         tfo3_ff <= (c2_ff.hits == HIT_TWO) ? tfo_ff : '0;
      end
   end

   assign out_ctl = c3_ff;
   assign t_near  = tno3_ff;
   assign t_far   = tfo3_ff;
   assign near_pt = nq_ff;
   assign far_pt  = fq_ff;

endmodule

// File: hdl/lsi_check.sv
// Port-level checks for the intersection pipeline, bound to the top level.
module lsi_check import lsi_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_hit_count,
   input logic signed [CW-1:0] rsp_t_near,
   input logic signed [CW-1:0] rsp_t_far,
   input logic signed [CW-1:0] rsp_near_x,
   input logic signed [CW-1:0] rsp_near_y,
   input logic signed [CW-1:0] rsp_near_z,
   input logic signed [CW-1:0] rsp_far_x,
   input logic signed [CW-1:0] rsp_far_y,
   input logic signed [CW-1:0] rsp_far_z
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_t_near) && $stable(rsp_hit_count))
      else $error("response changed while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count != 2'd3)
      else $error("hit count out of range");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count == HIT_NONE |->
         rsp_t_near == '0 && rsp_near_x == '0 && rsp_near_y == '0 && rsp_near_z == '0)
      else $error("miss with nonzero near fields");

   a_far: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count != HIT_TWO |->
         rsp_t_far == '0 && rsp_far_x == '0 && rsp_far_y == '0 && rsp_far_z == '0)
      else $error("far fields set without two hits");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count == HIT_TWO |-> rsp_t_near <= rsp_t_far)
      else $error("near parameter above far parameter");

endmodule

bind line_sphere_intersect_top lsi_check #(.CW(COORD_WIDTH)) u_lsi_check (.*);
